// ===== hw/rtl/hrhp_pkg.sv =====
// hrhp_pkg: shared types, codes and character-class helpers for the
// HTTP request header parser. No dependencies.
package hrhp_pkg;

	// accumulator width of each version number
	localparam int unsigned VersionWidth = 16;

	// status codes
	localparam logic [1:0] STATUS_PENDING = 2'd0;
	localparam logic [1:0] STATUS_DONE    = 2'd1;
	localparam logic [1:0] STATUS_BAD     = 2'd2;

	// byte tags
	localparam logic [2:0] TAG_NONE     = 3'd0;
	localparam logic [2:0] TAG_METHOD   = 3'd1;
	localparam logic [2:0] TAG_URI      = 3'd2;
	localparam logic [2:0] TAG_NEW_NAME = 3'd3;
	localparam logic [2:0] TAG_NAME     = 3'd4;
	localparam logic [2:0] TAG_VALUE    = 3'd5;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_US    = 8'h1F;

	// request word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} req_word_t;

	// result word
	typedef struct packed {
		logic [1:0]              status;
		logic [2:0]              byte_tag;
		logic [7:0]              char_out;
		logic [VersionWidth-1:0] version_major;
		logic [VersionWidth-1:0] version_minor;
	} res_word_t;

	// control characters, ASCII only
	function automatic logic is_ctl(input logic [7:0] c);
		return (c <= CH_US) || (c == CH_DEL);
	endfunction

	// separators of the token grammar
	function automatic logic is_special(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
			8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
			8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
			8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// token character: ASCII, no control, no separator
	function automatic logic is_token(input logic [7:0] c);
		return !c[7] && !is_ctl(c) && !is_special(c);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// acc * 10 + digit, saturating at all ones
	function automatic logic [VersionWidth-1:0] acc_digit(
		input logic [VersionWidth-1:0] acc,
		input logic [7:0]              c
	);
		logic [VersionWidth+3:0] wide;
		logic [VersionWidth+3:0] v;
		logic [VersionWidth+3:0] lim;
		wide = {4'b0000, acc};
		lim  = {4'b0000, {VersionWidth{1'b1}}};
		v    = (wide << 3) + (wide << 1) + {{VersionWidth{1'b0}}, c[3:0]};
		return (v > lim) ? {VersionWidth{1'b1}} : v[VersionWidth-1:0];
	endfunction

endpackage

// ===== hw/rtl/http_request_header_parser_top.sv =====
// http_request_header_parser_top: byte-serial HTTP/1.x request line and
// header parser. Depends on hrhp_pkg.

// One request byte per word in, one result word out per request word. A byte
// is registered at the input, runs through the parse state machine and the
// version accumulators, and lands in the output register when that register
// is free or drains. A new byte is taken every cycle as long as the output
// side keeps up. The parse state, the two version accumulators and the
// header flag advance once per byte. After a done or bad result the parser
// holds until a word with restart set.
module http_request_header_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  hrhp_pkg::req_word_t req_word,
	output logic               res_valid,
	input  logic               res_ready,
	output hrhp_pkg::res_word_t res_word
);
	import hrhp_pkg::*;

	// parse states
	localparam logic [4:0] ST_METHOD_START = 5'd0;
	localparam logic [4:0] ST_METHOD       = 5'd1;
	localparam logic [4:0] ST_URI          = 5'd2;
	localparam logic [4:0] ST_H            = 5'd3;
	localparam logic [4:0] ST_T1           = 5'd4;
	localparam logic [4:0] ST_T2           = 5'd5;
	localparam logic [4:0] ST_P            = 5'd6;
	localparam logic [4:0] ST_SLASH        = 5'd7;
	localparam logic [4:0] ST_MAJ_START    = 5'd8;
	localparam logic [4:0] ST_MAJ          = 5'd9;
	localparam logic [4:0] ST_MIN_START    = 5'd10;
	localparam logic [4:0] ST_MIN          = 5'd11;
	localparam logic [4:0] ST_NL1          = 5'd12;
	localparam logic [4:0] ST_LINE_START   = 5'd13;
	localparam logic [4:0] ST_LWS          = 5'd14;
	localparam logic [4:0] ST_NAME         = 5'd15;
	localparam logic [4:0] ST_SPACE        = 5'd16;
	localparam logic [4:0] ST_VALUE        = 5'd17;
	localparam logic [4:0] ST_NL2          = 5'd18;
	localparam logic [4:0] ST_NL3          = 5'd19;
	localparam logic [4:0] ST_DONE         = 5'd20;
	localparam logic [4:0] ST_BAD          = 5'd21;

	logic                    valid_s1;
	req_word_t               word_s1;
	logic                    adv;
	logic [4:0]              state_q;
	logic [VersionWidth-1:0] major_q;
	logic [VersionWidth-1:0] minor_q;
	logic                    hdr_seen_q;

	logic [4:0]              state_d;
	logic [VersionWidth-1:0] major_d;
	logic [VersionWidth-1:0] minor_d;
	logic                    hdr_seen_d;
	logic [2:0]              tag;
	logic                    bad;
	logic [4:0]              s;
	logic [7:0]              c;
	res_word_t               res_d;

	// handshake: stage 1 moves when the output register is free or drains
	assign adv       = valid_s1 && (!res_valid || res_ready);
	assign req_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			word_s1 <= req_word;
		end
	end

	// parse step for the byte in stage 1
	assign c = word_s1.data_byte;

	always_comb begin
		s          = state_q;
		tag        = TAG_NONE;
		bad        = 1'b0;
		major_d    = major_q;
		minor_d    = minor_q;
		hdr_seen_d = hdr_seen_q;
		state_d    = state_q;
		if (word_s1.restart) begin
			state_d    = ST_METHOD_START;
			hdr_seen_d = 1'b0;
		end else begin
			unique case (state_q)
				ST_METHOD_START: begin
					if (is_token(c)) begin
						s   = ST_METHOD;
						tag = TAG_METHOD;
					end else bad = 1'b1;
				end
				ST_METHOD: begin
					if (c == CH_SPACE) s = ST_URI;
					else if (is_token(c)) tag = TAG_METHOD;
					else bad = 1'b1;
				end
				ST_URI: begin
					if (c == CH_SPACE) s = ST_H;
					else if (is_ctl(c)) bad = 1'b1;
					else tag = TAG_URI;
				end
				ST_H: begin
					if (c == CH_H) s = ST_T1; else bad = 1'b1;
				end
				ST_T1: begin
					if (c == CH_T) s = ST_T2; else bad = 1'b1;
				end
				ST_T2: begin
					if (c == CH_T) s = ST_P; else bad = 1'b1;
				end
				ST_P: begin
					if (c == CH_P) s = ST_SLASH; else bad = 1'b1;
				end
				ST_SLASH: begin
					if (c == CH_SLASH) begin
						major_d = '0;
						minor_d = '0;
						s       = ST_MAJ_START;
					end else bad = 1'b1;
				end
				ST_MAJ_START: begin
					if (is_dig(c)) begin
						major_d = acc_digit(major_q, c);
						s       = ST_MAJ;
					end else bad = 1'b1;
				end
				ST_MAJ: begin
					if (c == CH_DOT) s = ST_MIN_START;
					else if (is_dig(c)) major_d = acc_digit(major_q, c);
					else bad = 1'b1;
				end
				ST_MIN_START: begin
					if (is_dig(c)) begin
						minor_d = acc_digit(minor_q, c);
						s       = ST_MIN;
					end else bad = 1'b1;
				end
				ST_MIN: begin
					if (c == CH_CR) s = ST_NL1;
					else if (is_dig(c)) minor_d = acc_digit(minor_q, c);
					else bad = 1'b1;
				end
				ST_NL1: begin
					if (c == CH_LF) s = ST_LINE_START; else bad = 1'b1;
				end
				ST_LINE_START: begin
					if (c == CH_CR) s = ST_NL3;
					else if (hdr_seen_q && (c == CH_SPACE || c == CH_TAB)) s = ST_LWS;
					else if (is_token(c)) begin
						hdr_seen_d = 1'b1;
						tag        = TAG_NEW_NAME;
						s          = ST_NAME;
					end else bad = 1'b1;
				end
				ST_LWS: begin
					if (c == CH_CR) s = ST_NL2;
					else if (c == CH_SPACE || c == CH_TAB) s = ST_LWS;
					else if (is_ctl(c)) bad = 1'b1;
					else begin
						s   = ST_VALUE;
						tag = TAG_VALUE;
					end
				end
				ST_NAME: begin
					if (c == CH_COLON) s = ST_SPACE;
					else if (is_token(c)) tag = TAG_NAME;
					else bad = 1'b1;
				end
				ST_SPACE: begin
					if (c == CH_SPACE) s = ST_VALUE; else bad = 1'b1;
				end
				ST_VALUE: begin
					if (c == CH_CR) s = ST_NL2;
					else if (is_ctl(c)) bad = 1'b1;
					else tag = TAG_VALUE;
				end
				ST_NL2: begin
					if (c == CH_LF) s = ST_LINE_START; else bad = 1'b1;
				end
				ST_NL3: begin
					if (c == CH_LF) s = ST_DONE; else bad = 1'b1;
				end
				ST_DONE: s = ST_DONE;
				default: bad = 1'b1;
			endcase
			if (bad) begin
				s   = ST_BAD;
				tag = TAG_NONE;
			end
			state_d = s;
		end
	end

	// result word for this byte
	always_comb begin
		res_d.status = STATUS_PENDING;
		if (!word_s1.restart) begin
			if (state_d == ST_DONE) res_d.status = STATUS_DONE;
			else if (state_d == ST_BAD) res_d.status = STATUS_BAD;
		end
		res_d.byte_tag      = tag;
		res_d.char_out      = (tag != TAG_NONE) ? c : 8'h00;
		res_d.version_major = major_d;
		res_d.version_minor = minor_d;
	end

	// parser state, advanced once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_METHOD_START;
			major_q    <= '0;
			minor_q    <= '0;
			hdr_seen_q <= 1'b0;
		end else if (adv) begin
			state_q    <= state_d;
			major_q    <= major_d;
			minor_q    <= minor_d;
			hdr_seen_q <= hdr_seen_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_word <= res_d;
		end
	end

endmodule

// ===== bench/http_request_header_parser_checker.sv =====
`timescale 1ns / 100ps
// http_request_header_parser_checker: watches both word channels of the parser,
// predicts every result word and compares it field by field.
// Depends on hrhp_pkg.
module http_request_header_parser_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  hrhp_pkg::req_word_t req_word,
	input  logic                res_valid,
	input  logic                res_ready,
	input  hrhp_pkg::res_word_t res_word,
	output int                  mismatch_count,
	output int                  outstanding,
	output int                  requests_done,
	output int                  requests_bad
);
	import hrhp_pkg::*;

	// parser position within the request
	typedef enum logic [4:0] {
		PS_METHOD_START,
		PS_METHOD,
		PS_URI,
		PS_H,
		PS_T1,
		PS_T2,
		PS_P,
		PS_SLASH,
		PS_MAJ_START,
		PS_MAJ,
		PS_MIN_START,
		PS_MIN,
		PS_LINE1_LF,
		PS_LINE_START,
		PS_FOLD,
		PS_NAME,
		PS_COLON_SP,
		PS_VALUE,
		PS_HDR_LF,
		PS_END_LF,
		PS_DONE,
		PS_BAD
	} parse_state_t;

	parse_state_t            ps;
	logic [VersionWidth-1:0] major_q;
	logic [VersionWidth-1:0] minor_q;
	bit                      hdr_seen;
	int                      done_total;
	int                      bad_total;
	int                      mismatches;
	int                      result_index;
	res_word_t               expected_results[$];
	res_word_t               want_w;

	// control characters: below space, and delete
	function automatic bit is_control(input logic [7:0] c);
		return (c < CH_SPACE) || (c == CH_DEL);
	endfunction

	// separators that end a token
	function automatic bit is_separator(input logic [7:0] c);
		bit hit;
		hit = 1'b0;
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", CH_SPACE, CH_TAB: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// high bytes (bit 7 set) are never token chars
	function automatic bit is_tchar(input logic [7:0] c);
		return (c < 8'd128) && !is_control(c) && !is_separator(c);
	endfunction

	function automatic bit is_numeral(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	// decimal shift-in that sticks at all ones
	function automatic logic [VersionWidth-1:0] push_digit(
		input logic [VersionWidth-1:0] acc,
		input logic [7:0]              c
	);
		longint unsigned ceiling;
		longint unsigned v;
		ceiling = (64'd1 << VersionWidth) - 64'd1;
		v = longint'(acc) * 10 + longint'(c - "0");
		if (v > ceiling)
			v = ceiling;
		return v[VersionWidth-1:0];
	endfunction

	// advance the parser by one request word and give the result word it causes
	function automatic res_word_t parse_byte(input req_word_t w);
		res_word_t    r;
		parse_state_t nxt;
		logic [2:0]   tag;
		logic [7:0]   c;
		bit           reject;
		c = w.data_byte;
		tag = TAG_NONE;
		reject = 1'b0;
		nxt = ps;
		r.status = STATUS_PENDING;
		if (w.restart) begin
			ps = PS_METHOD_START;
			hdr_seen = 1'b0;
		end else begin
			case (ps)
				PS_METHOD_START: begin
					if (is_tchar(c)) begin
						nxt = PS_METHOD;
						tag = TAG_METHOD;
					end else
						reject = 1'b1;
				end
				PS_METHOD: begin
					if (c == CH_SPACE)
						nxt = PS_URI;
					else if (is_tchar(c))
						tag = TAG_METHOD;
					else
						reject = 1'b1;
				end
				PS_URI: begin
					if (c == CH_SPACE)
						nxt = PS_H;
					else if (is_control(c))
						reject = 1'b1;
					else
						tag = TAG_URI;
				end
				PS_H:  if (c == CH_H) nxt = PS_T1; else reject = 1'b1;
				PS_T1: if (c == CH_T) nxt = PS_T2; else reject = 1'b1;
				PS_T2: if (c == CH_T) nxt = PS_P; else reject = 1'b1;
				PS_P:  if (c == CH_P) nxt = PS_SLASH; else reject = 1'b1;
				PS_SLASH: begin
					if (c == CH_SLASH) begin
						major_q = '0;
						minor_q = '0;
						nxt = PS_MAJ_START;
					end else
						reject = 1'b1;
				end
				PS_MAJ_START: begin
					if (is_numeral(c)) begin
						major_q = push_digit(major_q, c);
						nxt = PS_MAJ;
					end else
						reject = 1'b1;
				end
				PS_MAJ: begin
					if (c == CH_DOT)
						nxt = PS_MIN_START;
					else if (is_numeral(c))
						major_q = push_digit(major_q, c);
					else
						reject = 1'b1;
				end
				PS_MIN_START: begin
					if (is_numeral(c)) begin
						minor_q = push_digit(minor_q, c);
						nxt = PS_MIN;
					end else
						reject = 1'b1;
				end
				PS_MIN: begin
					if (c == CH_CR)
						nxt = PS_LINE1_LF;
					else if (is_numeral(c))
						minor_q = push_digit(minor_q, c);
					else
						reject = 1'b1;
				end
				PS_LINE1_LF: if (c == CH_LF) nxt = PS_LINE_START; else reject = 1'b1;
				PS_LINE_START: begin
					// folding is only legal once some header exists
					if (c == CH_CR)
						nxt = PS_END_LF;
					else if (hdr_seen && is_blank(c))
						nxt = PS_FOLD;
					else if (is_tchar(c)) begin
						hdr_seen = 1'b1;
						tag = TAG_NEW_NAME;
						nxt = PS_NAME;
					end else
						reject = 1'b1;
				end
				PS_FOLD: begin
					if (c == CH_CR)
						nxt = PS_HDR_LF;
					else if (is_blank(c))
						nxt = PS_FOLD;
					else if (is_control(c))
						reject = 1'b1;
					else begin
						nxt = PS_VALUE;
						tag = TAG_VALUE;
					end
				end
				PS_NAME: begin
					if (c == CH_COLON)
						nxt = PS_COLON_SP;
					else if (is_tchar(c))
						tag = TAG_NAME;
					else
						reject = 1'b1;
				end
				PS_COLON_SP: if (c == CH_SPACE) nxt = PS_VALUE; else reject = 1'b1;
				PS_VALUE: begin
					if (c == CH_CR)
						nxt = PS_HDR_LF;
					else if (is_control(c))
						reject = 1'b1;
					else
						tag = TAG_VALUE;
				end
				PS_HDR_LF: if (c == CH_LF) nxt = PS_LINE_START; else reject = 1'b1;
				PS_END_LF: if (c == CH_LF) nxt = PS_DONE; else reject = 1'b1;
				PS_DONE: nxt = PS_DONE;
				default: reject = 1'b1;
			endcase
			if (reject) begin
				nxt = PS_BAD;
				tag = TAG_NONE;
			end
			if (nxt == PS_DONE && ps != PS_DONE)
				done_total++;
			if (nxt == PS_BAD && ps != PS_BAD)
				bad_total++;
			ps = nxt;
			if (ps == PS_DONE)
				r.status = STATUS_DONE;
			else if (ps == PS_BAD)
				r.status = STATUS_BAD;
		end
		r.byte_tag = tag;
		r.char_out = (tag != TAG_NONE) ? c : 8'd0;
		r.version_major = major_q;
		r.version_minor = minor_q;
		return r;
	endfunction

	// count a field that differs, report only the first few
	task automatic flag_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s of result %0d: expected %0h, got %0h",
					field, result_index, want, got);
		end
	endtask

	// compare taken result words first, then queue the prediction for a taken request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps = PS_METHOD_START;
			major_q = '0;
			minor_q = '0;
			hdr_seen = 1'b0;
			done_total = 0;
			bad_total = 0;
			mismatches = 0;
			result_index = 0;
			expected_results.delete();
			mismatch_count <= 0;
			outstanding <= 0;
			requests_done <= 0;
			requests_bad <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no request pending: %0h",
							result_index, res_word);
				end else begin
					want_w = expected_results.pop_front();
					flag_field("status", 32'(res_word.status), 32'(want_w.status));
					flag_field("byte_tag", 32'(res_word.byte_tag),
						32'(want_w.byte_tag));
					flag_field("char_out", 32'(res_word.char_out),
						32'(want_w.char_out));
					flag_field("version_major", 32'(res_word.version_major),
						32'(want_w.version_major));
					flag_field("version_minor", 32'(res_word.version_minor),
						32'(want_w.version_minor));
				end
				result_index++;
			end
			if (req_valid && req_ready)
				expected_results.insert(expected_results.size(), parse_byte(req_word));
			mismatch_count <= mismatches;
			outstanding <= expected_results.size();
			requests_done <= done_total;
			requests_bad <= bad_total;
		end
	end

endmodule

// ===== bench/http_request_header_parser_top_test.sv =====
`timescale 1ns / 100ps
// http_request_header_parser_top_test: drives request bytes into the parser,
// throttles the result side and reports the verdict.
// Depends on hrhp_pkg, http_request_header_parser_top and the checker.
module http_request_header_parser_top_test;
	import hrhp_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_word_t req_word;
	logic      res_valid;
	logic      res_ready;
	res_word_t res_word;

	int mismatch_count;
	int outstanding;
	int requests_done;
	int requests_bad;

	// stimulus controls; quiet and hold_req are updated with nonblocking assignments
	bit quiet;
	bit hold_req;
	bit hold_served;

	int         words_sent;
	int         restarts_sent;
	int         items;
	logic [7:0] msg[$];
	string      token_set =
		"!#$%&'*+-.^_`|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

	http_request_header_parser_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	http_request_header_parser_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req_word       (req_word),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res_word       (res_word),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.requests_done  (requests_done),
		.requests_bad   (requests_bad)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// single reset pulse at the start
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d results still pending", outstanding);
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		res_ready = 1'b0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				res_ready <= 1'b0;
				for (int i = 0; i < 80; i++)
					@(posedge clk);
			end else if (quiet)
				res_ready <= 1'b1;
			else
				res_ready <= ($urandom_range(99) >= 14);
		end
	end

	// offer one request word and wait for it to be taken
	task automatic send_word(input logic [7:0] b, input logic rst);
		req_word_t w;
		w.data_byte = b;
		w.restart = rst;
		while (!quiet && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		words_sent++;
		if (rst)
			restarts_sent++;
	endtask

	// stop offering until every result word is back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// append one byte to the message
	task automatic add_byte(input logic [7:0] b);
		msg.insert(msg.size(), b);
	endtask

	task automatic push_string(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_token();
		return token_set[$urandom_range(token_set.len() - 1)];
	endfunction

	// any non-control byte, high bytes included; space only where allowed
	function automatic logic [7:0] pick_text(input bit allow_space);
		logic [7:0] c;
		c = 8'($urandom_range(255, allow_space ? 32 : 33));
		if (c == CH_DEL)
			c = 8'h80;
		return c;
	endfunction

	// mostly short numbers, now and then long enough to saturate
	task automatic push_digits();
		int n;
		n = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(2, 1);
		repeat (n) add_byte(8'("0" + $urandom_range(9)));
	endtask

	// well-formed request with random content
	task automatic build_request();
		int n;
		int hdrs;
		msg.delete();
		n = $urandom_range(6, 1);
		repeat (n) add_byte(pick_token());
		add_byte(CH_SPACE);
		n = $urandom_range(10, 1);
		repeat (n) add_byte(pick_text(1'b0));
		push_string(" HTTP/");
		push_digits();
		add_byte(CH_DOT);
		push_digits();
		add_byte(CH_CR);
		add_byte(CH_LF);
		hdrs = $urandom_range(3);
		for (int h = 0; h < hdrs; h++) begin
			n = $urandom_range(6, 1);
			repeat (n) add_byte(pick_token());
			add_byte(CH_COLON);
			add_byte(CH_SPACE);
			n = $urandom_range(8);
			repeat (n) add_byte(pick_text(1'b1));
			add_byte(CH_CR);
			add_byte(CH_LF);
			// folded continuation line
			if ($urandom_range(2) == 0) begin
				n = $urandom_range(3, 1);
				repeat (n) add_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
				n = $urandom_range(5);
				repeat (n) add_byte(pick_text(1'b1));
				add_byte(CH_CR);
				add_byte(CH_LF);
			end
		end
		add_byte(CH_CR);
		add_byte(CH_LF);
	endtask

	task automatic send_msg();
		for (int i = 0; i < msg.size(); i++)
			send_word(msg[i], 1'b0);
		items += msg.size();
	endtask

	// stimulus
	initial begin
		int  kind;
		int  cut;
		bit  hold_fired;
		bit  pause_done;
		req_valid = 1'b0;
		req_word = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		words_sent = 0;
		restarts_sent = 0;
		items = 0;
		hold_fired = 1'b0;
		pause_done = 1'b0;
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);

		// high byte in the uri, saturating minor version, fold before any header,
		// then a zero byte in the held bad state
		msg.delete();
		push_string("A ");
		add_byte(8'hFF);
		push_string(" HTTP/0.9999999");
		add_byte(CH_CR);
		add_byte(CH_LF);
		add_byte(CH_SPACE);
		add_byte(8'h00);
		send_msg();
		send_word(8'hFF, 1'b1);
		// high byte rejected as a method char, then restart with a zero byte
		send_word(8'h80, 1'b0);
		send_word(8'h00, 1'b1);
		items += 2;
		drain();

		// random part: mostly requests, some broken, cut short or pure noise
		while (items < 400) begin
			if (items >= 120 && !hold_fired) begin
				hold_fired = 1'b1;
				hold_req <= 1'b1;
			end
			if (items >= 220 && !pause_done) begin
				pause_done = 1'b1;
				drain();
			end
			quiet <= (items >= 280 && items < 340);
			kind = $urandom_range(99);
			if (kind < 85) begin
				build_request();
				if (kind < 15) begin
					cut = $urandom_range(msg.size() - 1, 1);
					while (msg.size() > cut)
						void'(msg.pop_back());
				end else if (kind < 35)
					msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
				send_msg();
				// bytes that land in the held done or bad state
				if (kind >= 15)
					repeat ($urandom_range(2)) send_word(8'($urandom_range(255)), 1'b0);
				send_word(8'($urandom_range(255)), 1'b1);
			end else begin
				cut = $urandom_range(6, 1);
				repeat (cut) send_word(8'($urandom_range(255)), $urandom_range(4) == 0);
				items += cut;
			end
		end
		quiet <= 1'b0;

		// wait for the last results, then let the clock run on for strays
		drain();
		repeat (10) @(posedge clk);
		$display("%0d words taken, %0d of them restarts", words_sent, restarts_sent);
		$display("%0d requests parsed to completion, %0d rejected, %0d field mismatches",
			requests_done, requests_bad, mismatch_count);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== http_request_header_parser_top.f =====
hw/rtl/hrhp_pkg.sv
hw/rtl/http_request_header_parser_top.sv
bench/http_request_header_parser_checker.sv
bench/http_request_header_parser_top_test.sv
